[rtl/vld_pkg.sv]
`timescale 1ns / 1ps

package vld_pkg;

  // Field widths
  localparam int unsigned ByteW    = 8;
  localparam int unsigned GroupW   = 7;
  localparam int unsigned ValueW   = 33;
  localparam int unsigned SValueW  = 32;

  // APB register map: one 64-bit register per 8-byte slot
  localparam int unsigned PaddrW   = 4;
  localparam int unsigned PdataW   = 64;
  localparam int unsigned RegIdxLo = 3;

  // Register indexes (paddr[PaddrW-1:RegIdxLo])
  localparam logic [PaddrW-RegIdxLo-1:0] RegValueLimit = '0;

  // Reset value of the limit register
  localparam logic [ValueW-1:0] LimitReset = 33'h0_FFFF_FFFF;

  // Byte layout
  localparam int unsigned ContBit  = 7;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FORMAT = 2'd1,
    ST_TRUNC  = 2'd2
  } status_e;

  typedef struct packed {
    status_e                    status;
    logic [ValueW-1:0]          value;
    logic signed [SValueW-1:0]  signed_value;
  } result_t;

endpackage

[rtl/varint_limit_decoder_unit.sv]
`timescale 1ns / 1ps

// Channel  | direction | handshake               | word
// ---------+-----------+-------------------------+---------------------------------------
// in       | in        | in_valid_i / in_stall_o | data_byte_i, end_of_buffer_i
// out      | out       | out_valid_o/out_stall_i | status_o, value_o, signed_value_o
// cfg      | in        | APB psel/penable/pready | value_limit at byte address 0
//
// One input word is taken every cycle while in_stall_o is low; the result of the word that
// completes, rejects or truncates a value is registered in the output or skid register.
// The per-word work (limit compare, 7-bit merge, final compare, zigzag) runs combinationally
// from the accumulator register into the output register, or the skid register on a stall.
// Reset clears the accumulator, the output and skid valids, and loads value_limit with
// 0xFFFFFFFF.
// A stalled output is backed by a one-word skid register; in_stall_o rises only when
// the skid register is occupied.
module varint_limit_decoder_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // input channel
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [vld_pkg::ByteW-1:0]            data_byte_i,
  input  logic                                 end_of_buffer_i,
  // output channel
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output vld_pkg::status_e                     status_o,
  output logic [vld_pkg::ValueW-1:0]           value_o,
  output logic signed [vld_pkg::SValueW-1:0]   signed_value_o,
  // configuration port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [vld_pkg::PaddrW-1:0]           paddr,
  input  logic [vld_pkg::PdataW-1:0]           pwdata,
  output logic [vld_pkg::PdataW-1:0]           prdata,
  output logic                                 pready
);
  import vld_pkg::*;

  logic [ValueW-1:0]          limit_q;
  logic [ValueW-1:0]          acc_q, acc_d;
  logic                       reg_sel;
  logic                       in_fire;
  logic                       out_fire;
  logic [ValueW-1:0]          lim_shr;
  logic                       early_ovf;
  logic [ValueW-1:0]          merged;
  logic                       cont;
  logic                       res_valid;
  result_t                    res;
  logic [SValueW-1:0]         zz;
  result_t                    out_q, skid_q;
  logic                       out_v_q, skid_v_q;

  // Configuration register
  assign pready  = 1'b1;
  assign reg_sel = (paddr[PaddrW-1:RegIdxLo] == RegValueLimit);
  assign prdata  = reg_sel ? {{(PdataW-ValueW){1'b0}}, limit_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LimitReset;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      limit_q <= pwdata[ValueW-1:0];
    end
  end

  // Handshakes
  assign in_stall_o = skid_v_q;
  assign in_fire    = in_valid_i && !in_stall_o;
  assign out_fire   = out_v_q && !out_stall_i;

  // Per-word decode: early limit check, merge, final check
  assign lim_shr   = limit_q >> GroupW;
  assign early_ovf = (acc_q > lim_shr);
  assign merged    = {acc_q[ValueW-GroupW-1:0], data_byte_i[GroupW-1:0]};
  assign cont      = data_byte_i[ContBit];
  assign zz        = {1'b0, merged[SValueW-1:1]} ^ {SValueW{merged[0]}};

  always_comb begin
    acc_d            = acc_q;
    res_valid        = 1'b0;
    res.status       = ST_OK;
    res.value        = '0;
    res.signed_value = '0;
    if (in_fire) begin
      priority if (early_ovf) begin
        res_valid  = 1'b1;
        res.status = ST_FORMAT;
        acc_d      = '0;
      end else if (!cont) begin
        res_valid = 1'b1;
        acc_d     = '0;
        if (merged > limit_q) begin
          res.status = ST_FORMAT;
        end else begin
          res.status       = ST_OK;
          res.value        = merged;
          res.signed_value = zz;
        end
      end else if (end_of_buffer_i) begin
        res_valid  = 1'b1;
        res.status = ST_TRUNC;
        acc_d      = '0;
      end else begin
        acc_d = merged;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  // Output register with one-word skid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (!out_v_q || out_fire) begin
      if (skid_v_q) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end else begin
        out_v_q <= res_valid;
      end
    end else if (res_valid) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_v_q || out_fire) begin
      if (skid_v_q) begin
        out_q <= skid_q;
      end else if (res_valid) begin
        out_q <= res;
      end
    end else if (res_valid) begin
      skid_q <= res;
    end
  end

  assign out_valid_o    = out_v_q;
  assign status_o       = out_q.status;
  assign value_o        = out_q.value;
  assign signed_value_o = out_q.signed_value;

  // Checks
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid word held while output register empty");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_q.status != ST_OK) |-> (out_q.value == '0 && out_q.signed_value == '0))
    else $error("failed result carries a nonzero value");

  a_acc_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |=> (acc_q == '0))
    else $error("accumulator not cleared after a result");

  a_ok_in_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && res.status == ST_OK) |-> (res.value <= limit_q))
    else $error("ok result above limit");

endmodule

[tb/varint_limit_decoder_unit_test.sv]
`timescale 1ns / 1ps

module varint_limit_decoder_unit_test;
  import vld_pkg::*;

  localparam logic [PaddrW-1:0] LimitAddr = PaddrW'(RegValueLimit) << RegIdxLo;
  localparam int unsigned PhaseCount = 9;
  localparam int unsigned WordsPerPhase = 150;
  localparam logic [ValueW-1:0] LimitTop = 33'h1_0000_0000;

  // Opening words {end_of_buffer, data_byte}: extremes, all three statuses,
  // early limit rejects, restart after a reject, end flag on a final byte
  localparam logic [ByteW:0] OpeningWords [0:24] = '{
    9'h000, 9'h07F, 9'h180, 9'h0FF, 9'h07F,
    9'h08F, 9'h0FF, 9'h0FF, 9'h0FF, 9'h07F,
    9'h090, 9'h080, 9'h080, 9'h080, 9'h100,
    9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF,
    9'h001, 9'h105, 9'h080, 9'h102, 9'h1FF
  };

  // Tracks the decoder state and the results still owed by the block
  class varint_decode_tracker;
    logic [ValueW-1:0] limit;
    logic [ValueW-1:0] acc;
    result_t           owed_q[$];
    int unsigned       mismatches;

    function new();
      limit      = LimitReset;
      acc        = '0;
      mismatches = 0;
    endfunction

    function int unsigned pending_count();
      return owed_q.size();
    endfunction

    // Closes the current value with the given status; failed values carry zeros
    function void close_value(status_e st);
      result_t           r;
      logic [SValueW-1:0] low;
      low = acc[SValueW-1:0];
      r.status       = st;
      r.value        = '0;
      r.signed_value = '0;
      if (st == ST_OK) begin
        r.value        = acc;
        r.signed_value = $signed((low >> 1) ^ {SValueW{low[0]}});
      end
      owed_q.push_back(r);
      acc = '0;
    endfunction

    // Called for every accepted input word
    function void note_byte(logic [ByteW-1:0] b, logic eob);
      if (acc > (limit >> GroupW)) begin
        close_value(ST_FORMAT);
        return;
      end
      acc = (acc << GroupW) | ValueW'(b[GroupW-1:0]);
      if (!b[ContBit]) begin
        if (acc > limit) close_value(ST_FORMAT);
        else close_value(ST_OK);
      end else if (eob) begin
        close_value(ST_TRUNC);
      end
    endfunction

    // Called for every accepted output word
    function void check_result(status_e st, logic [ValueW-1:0] val,
                               logic signed [SValueW-1:0] sval);
      result_t exp_r;
      if (owed_q.size() == 0) begin
        $error("unexpected result: status %0d value %h signed_value %0d", st, val, sval);
        mismatches++;
        return;
      end
      exp_r = owed_q.pop_front();
      if (st !== exp_r.status) begin
        $error("status: expected %0d actual %0d", exp_r.status, st);
        mismatches++;
      end
      if (val !== exp_r.value) begin
        $error("value: expected %h actual %h", exp_r.value, val);
        mismatches++;
      end
      if (sval !== exp_r.signed_value) begin
        $error("signed_value: expected %0d actual %0d", exp_r.signed_value, sval);
        mismatches++;
      end
    endfunction
  endclass

  logic                      clk_i;
  logic                      rst_ni;
  logic                      in_valid_i;
  logic                      in_stall_o;
  logic [ByteW-1:0]          data_byte_i;
  logic                      end_of_buffer_i;
  logic                      out_valid_o;
  logic                      out_stall_i;
  status_e                   status_o;
  logic [ValueW-1:0]         value_o;
  logic signed [SValueW-1:0] signed_value_o;
  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic [PaddrW-1:0]         paddr;
  logic [PdataW-1:0]         pwdata;
  logic [PdataW-1:0]         prdata;
  logic                      pready;

  varint_decode_tracker tracker = new();
  bit                   steady = 1'b0;
  int unsigned          words_sent = 0;

  varint_limit_decoder_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .data_byte_i     (data_byte_i),
    .end_of_buffer_i (end_of_buffer_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .value_o         (value_o),
    .signed_value_o  (signed_value_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop
  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Output side: check accepted words, stall at random
  initial begin
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        tracker.check_result(status_o, value_o, signed_value_o);
      end
      out_stall_i <= !steady && ($urandom_range(0, 99) < 32);
    end
  end

  // One input word, with a random gap ahead of it; returns after acceptance
  task automatic send_word(input logic [ByteW-1:0] b, input logic eob);
    while (!steady && $urandom_range(0, 99) < 32) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    data_byte_i     <= b;
    end_of_buffer_i <= eob;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    tracker.note_byte(b, eob);
    words_sent++;
  endtask

  // Encodes a value MSB group first, optionally padded or cut short
  task automatic send_value(input logic [ValueW-1:0] v, input int lead_zeros, input bit cut);
    int               groups;
    int               total;
    int               cut_at;
    logic [ByteW-1:0] b;
    groups = 1;
    while (groups < 5 && (v >> (GroupW * groups)) != 0) groups++;
    total  = groups + lead_zeros;
    cut_at = (cut && total > 1) ? int'($urandom_range(1, total - 1)) : 0;
    for (int i = total - 1; i >= 0; i--) begin
      b[GroupW-1:0] = (i < groups) ? GroupW'(v >> (GroupW * i)) : '0;
      b[ContBit]    = (i != 0);
      if (cut_at != 0 && i == cut_at) begin
        send_word(b, 1'b1);
        break;
      end
      send_word(b, (i == 0) ? 1'($urandom_range(0, 1)) : 1'b0);
    end
  endtask

  // One APB transfer; leaves psel high so transfers can run back to back
  task automatic apb_transfer(input bit wr, input logic [PdataW-1:0] wdata,
                              output logic [PdataW-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= LimitAddr;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
  endtask

  // Optional write of the limit, then read-back
  task automatic program_limit(input logic [ValueW-1:0] lim, input bit wr);
    logic [PdataW-1:0] rd;
    if (wr) begin
      apb_transfer(1'b1, PdataW'(lim), rd);
      tracker.limit = lim;
    end
    apb_transfer(1'b0, '0, rd);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd[ValueW-1:0] !== lim) begin
      $error("value_limit read-back: expected %h actual %h", lim, rd[ValueW-1:0]);
      tracker.mismatches++;
    end
  endtask

  // Random mix: mostly well-formed encodings, some raw noise
  task automatic random_words(input int unsigned count);
    int unsigned       target;
    logic [ValueW-1:0] v;
    longint            near;
    target = words_sent + count;
    while (words_sent < target) begin
      if ($urandom_range(0, 99) < 78) begin
        case ($urandom_range(0, 5))
          0: v = ValueW'($urandom_range(0, 127));
          1: v = ValueW'($urandom) >> $urandom_range(0, 31);
          2: v = {1'($urandom_range(0, 1)), 32'($urandom)};
          3: begin
            // prefix at or one above the early-check bound
            v = (((tracker.limit >> GroupW) + ValueW'($urandom_range(0, 1))) << GroupW)
                | ValueW'($urandom_range(0, 127));
          end
          default: begin
            near = longint'(tracker.limit) + longint'($urandom_range(0, 6)) - 3;
            if (near < 0) near = 0;
            v = ValueW'(near);
          end
        endcase
        send_value(v, ($urandom_range(0, 9) == 0) ? int'($urandom_range(1, 2)) : 0,
                   $urandom_range(0, 99) < 8);
      end else begin
        send_word(ByteW'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
      end
    end
  endtask

  // Main sequence
  initial begin
    logic [ValueW-1:0] limits [PhaseCount];
    rst_ni          <= 1'b0;
    in_valid_i      <= 1'b0;
    data_byte_i     <= '0;
    end_of_buffer_i <= 1'b0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    limits = '{LimitReset, '0, LimitTop, 33'd127, 33'd128, 33'd16383,
               ValueW'($urandom_range(1, 100000)), ValueW'($urandom), LimitReset};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int p = 0; p < PhaseCount; p++) begin
      program_limit(limits[p], p != 0);
      steady = (p == 2);
      if (p == 0) begin
        foreach (OpeningWords[i]) send_word(OpeningWords[i][ByteW-1:0], OpeningWords[i][ByteW]);
        random_words(WordsPerPhase - $size(OpeningWords));
      end else begin
        random_words(WordsPerPhase);
      end
      in_valid_i <= 1'b0;
      steady = 1'b0;
      // drain, then give the block time to settle before touching the register
      while (tracker.pending_count() != 0) @(posedge clk_i);
      repeat (4) @(posedge clk_i);
    end

    if (tracker.mismatches == 0 && tracker.pending_count() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
